// ----- rtl/bti_pkg.sv -----
// Shared constants and types for the binary trie insert/lookup unit.
package bti_pkg;

  localparam int NODES    = 65536;
  localparam int KEY_BITS = 31;
  localparam int NODE_W   = $clog2(NODES);
  localparam int IDX_W    = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int LEFT_W   = $clog2(KEY_BITS + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [KEY_BITS-1:0] key;
  } request_t;

  typedef struct packed {
    logic present;
    logic overflow;
  } result_t;

  // One trie node: both child links and the presence mark.
  typedef struct packed {
    logic              present;
    logic [NODE_W-1:0] child1;
    logic [NODE_W-1:0] child0;
  } node_entry_t;

  localparam int ENTRY_W = $bits(node_entry_t);

endpackage

// ----- rtl/binary_trie_insert_lookup_unit.sv -----
// Top level of the binary trie insert/lookup unit.
//
// Command channel: a request (operation, key) transfers at a rising edge with
// start high and busy low. operation 0 inserts the key, 1 looks it up.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot stall it. present reports a stored key on a lookup,
// overflow reports an insert that ran out of free nodes.
// Each request walks the trie from the root: one node-memory read per trie
// level, the next read issued from the data of the current one, plus one read
// of the final node. A lookup that misses or an insert that overflows ends
// early, at the level where it stops.
// busy drops in the done cycle, so a new request may transfer at the edge that
// ends it; requests are handled one at a time.
// All nodes live in one memory of NODES entries (both child links and the
// presence bit). After reset the unit clears that memory, one entry per
// cycle, with busy high.
module binary_trie_insert_lookup_unit
  import bti_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } state_t;

  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODES - 1);

  state_t            state;
  request_t          req;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] node_count;
  logic [NODE_W-1:0] clr_addr;
  logic [LEFT_W-1:0] bits_left;

  logic              ram_we;
  logic [NODE_W-1:0] ram_waddr;
  logic [NODE_W-1:0] ram_raddr;
  node_entry_t       ram_wentry;
  logic [ENTRY_W-1:0] ram_rdata;
  node_entry_t       cur;

  logic [IDX_W-1:0]  bit_idx;
  logic              bit_sel;
  logic [NODE_W-1:0] next_node;
  logic [NODE_W-1:0] alloc_node;
  logic              table_full;
  logic              last_level;

  assign cur        = node_entry_t'(ram_rdata);
  assign bit_idx    = IDX_W'(bits_left - LEFT_W'(1));
  assign bit_sel    = req.key[bit_idx];
  assign next_node  = bit_sel ? cur.child1 : cur.child0;
  assign alloc_node = node_count + NODE_W'(1);
  assign table_full = (node_count == NODE_LAST);
  assign last_level = (bits_left == '0);
  assign busy       = (state != S_IDLE);

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = node;
    ram_wentry = cur;
    ram_raddr  = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr;
        ram_wentry = '0;
      end
      S_IDLE: begin
        ram_raddr = '0;
      end
      S_WALK: begin
        if (last_level) begin
          if (req.operation == OP_INSERT) begin
            ram_we             = 1'b1;
            ram_wentry.present = 1'b1;
          end
        end else if (next_node == '0) begin
          ram_raddr = alloc_node;
          if (req.operation == OP_INSERT && !table_full) begin
            ram_we = 1'b1;
            if (bit_sel) begin
              ram_wentry.child1 = alloc_node;
            end else begin
              ram_wentry.child0 = alloc_node;
            end
          end
        end else begin
          ram_raddr = next_node;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      node_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NODE_W'(1);
          if (clr_addr == NODE_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            req       <= request;
            node      <= '0;
            bits_left <= LEFT_W'(KEY_BITS);
            state     <= S_WALK;
          end
        end
        S_WALK: begin
          if (last_level) begin
            done            <= 1'b1;
            result.overflow <= 1'b0;
            result.present  <= (req.operation == OP_FIND) ? cur.present : 1'b0;
            state           <= S_IDLE;
          end else if (next_node == '0) begin
            if (req.operation == OP_FIND) begin
              done           <= 1'b1;
              result         <= '0;
              state          <= S_IDLE;
            end else if (table_full) begin
              done            <= 1'b1;
              result.present  <= 1'b0;
              result.overflow <= 1'b1;
              state           <= S_IDLE;
            end else begin
              node_count <= alloc_node;
              node       <= alloc_node;
              bits_left  <= bits_left - LEFT_W'(1);
            end
          end else begin
            node      <= next_node;
            bits_left <= bits_left - LEFT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  bti_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ENTRY_W'(ram_wentry)),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- rtl/bti_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module bti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
